// ===== hdl/kwm_pkg.sv =====
package kwm_pkg;

  // fixed field widths of one beat
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LIST_W  = 3;

  // request kinds
  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } kwm_req_e;

  // result codes
  typedef enum logic [1:0] {
    STAT_PUSHED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_POPPED  = 2'd2,
    STAT_EMPTY   = 2'd3
  } kwm_status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_POP_CTRL,
    ST_POP_HEAD,
    ST_RESP
  } kwm_state_e;

  // input beat
  typedef struct packed {
    kwm_req_e                  req_type;
    logic [LIST_W-1:0]         list_index;
    logic signed [VALUE_W-1:0] value;
  } kwm_req_t;

  // output beat
  typedef struct packed {
    kwm_status_e               status;
    logic signed [VALUE_W-1:0] out_value;
    logic [LIST_W-1:0]         source_list;
  } kwm_resp_t;

endpackage

// ===== hdl/kwm_ram.sv =====
module kwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/kwm_min_tree.sv =====
module kwm_min_tree #(
  parameter int unsigned NUM_LISTS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [NUM_LISTS-1:0]                 head_vld_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0]   head_val_i [NUM_LISTS],
  output logic                                 done_o,
  output logic [$clog2(NUM_LISTS)-1:0]         idx_o,
  output logic signed [kwm_pkg::VALUE_W-1:0]   val_o
);

  localparam int unsigned LW   = $clog2(NUM_LISTS);
  localparam int unsigned P    = 1 << LW;
  localparam int unsigned HALF = P / 2;
  localparam int unsigned SCW  = $clog2(LW + 1);

  logic                               c_vld_q [P];
  logic                               c_vld_d [P];
  logic [LW-1:0]                      c_idx_q [P];
  logic [LW-1:0]                      c_idx_d [P];
  logic signed [kwm_pkg::VALUE_W-1:0] c_val_q [P];
  logic signed [kwm_pkg::VALUE_W-1:0] c_val_d [P];
  logic                               ld_vld  [P];
  logic signed [kwm_pkg::VALUE_W-1:0] ld_val  [P];
  logic                               busy_q, busy_d;
  logic [SCW-1:0]                     step_q, step_d;
  logic                               done;

  // pad the heads up to a power of two with empty slots
  for (genvar g = 0; g < P; g++) begin : g_pad
    if (g < NUM_LISTS) begin : g_real
      assign ld_vld[g] = head_vld_i[g];
      assign ld_val[g] = head_val_i[g];
    end else begin : g_fill
      assign ld_vld[g] = 1'b0;
      assign ld_val[g] = '0;
    end
  end

  assign done = busy_q && (step_q == SCW'(LW));

  // one tree level per cycle, lower index kept on equal values
  always_comb begin
    for (int i = 0; i < P; i++) begin
      c_vld_d[i] = c_vld_q[i];
      c_idx_d[i] = c_idx_q[i];
      c_val_d[i] = c_val_q[i];
    end
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      for (int i = 0; i < P; i++) begin
        c_vld_d[i] = ld_vld[i];
        c_idx_d[i] = LW'(i);
        c_val_d[i] = ld_val[i];
      end
      busy_d = 1'b1;
      step_d = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      for (int i = 0; i < HALF; i++) begin
        if (c_vld_q[2*i+1] && (!c_vld_q[2*i] || (c_val_q[2*i+1] < c_val_q[2*i]))) begin
          c_vld_d[i] = c_vld_q[2*i+1];
          c_idx_d[i] = c_idx_q[2*i+1];
          c_val_d[i] = c_val_q[2*i+1];
        end else begin
          c_vld_d[i] = c_vld_q[2*i];
          c_idx_d[i] = c_idx_q[2*i];
          c_val_d[i] = c_val_q[2*i];
        end
      end
      for (int i = HALF; i < P; i++) begin
        c_vld_d[i] = 1'b0;
      end
      step_d = step_q + SCW'(1);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // candidate slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < P; i++) begin
      c_vld_q[i] <= c_vld_d[i];
      c_idx_q[i] <= c_idx_d[i];
      c_val_q[i] <= c_val_d[i];
    end
  end

  assign done_o = done;
  assign idx_o  = c_idx_q[0];
  assign val_o  = c_val_q[0];

endmodule

// ===== hdl/k_way_sorted_merge.sv =====
// channel | direction | beat type          | handshake
// in      | input     | kwm_pkg::kwm_req_t  | in_valid_i / in_ready_o
// out     | output    | kwm_pkg::kwm_resp_t | out_valid_o / out_ready_i
//
// push: pointer memory read, then store and pointer write.
// pop: the min tree over the head registers (one level a cycle), then the pointer read,
// head refill read and result; no head refill read when the popped list runs empty.
// push to a missing list or pop with all lists empty: straight to the result.
// reset clears head valid bits and pointer-entry valid bits at once; no sweep.
// a stalled output holds the next result back, and the next beat is taken as
// soon as the pending result moves into the output register.
module k_way_sorted_merge #(
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kwm_pkg::kwm_req_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kwm_pkg::kwm_resp_t  out_data_o
);

  localparam int unsigned LW = $clog2(NUM_LISTS);
  localparam int unsigned PW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW = PW + 1;
  localparam int unsigned EW = PW + CW;
  localparam int unsigned DW = kwm_pkg::VALUE_W;

  // position wrap, inputs stay below twice the depth
  function automatic logic [PW-1:0] wrap_pos(input logic [SW-1:0] s);
    logic [PW-1:0] r;
    if (s >= SW'(LIST_DEPTH)) begin
      r = PW'(s - SW'(LIST_DEPTH));
    end else begin
      r = PW'(s);
    end
    return r;
  endfunction

  kwm_pkg::kwm_state_e state_q, state_d;
  kwm_pkg::kwm_req_t   req_q;
  kwm_pkg::kwm_resp_t  res_q, res_d, out_q;
  logic                res_en, out_load, out_vld_q, out_free;
  logic [LW-1:0]       cur_list_q, cur_list_d;
  logic                cur_load, in_ready, req_load;
  logic [LW-1:0]       in_list;
  logic                push_ok;

  // head cache, one per list
  logic signed [DW-1:0] head_val_q [NUM_LISTS];
  logic [NUM_LISTS-1:0] head_vld_q;
  logic                 head_wr_en, head_wr_vld;
  logic signed [DW-1:0] head_wr_val;

  // pointer memory: read position and fill count per list
  logic                 ctrl_rd_en, ctrl_wr_en;
  logic [LW-1:0]        ctrl_rd_addr, ctrl_rd_addr_q;
  logic [EW-1:0]        ctrl_raw, ctrl_entry, ctrl_wr_data;
  logic [NUM_LISTS-1:0] ctrl_seen_q;
  logic [PW-1:0]        ctrl_rp, ctrl_wr_rp, next_rp;
  logic [CW-1:0]        ctrl_cnt, ctrl_wr_cnt;

  // list store
  logic                 dat_wr_en, dat_rd_en;
  logic [LW+PW-1:0]     dat_wr_addr, dat_rd_addr;
  logic [DW-1:0]        dat_rdata;

  // min tree
  logic                 tree_start, tree_done;
  logic [LW-1:0]        tree_idx;
  logic signed [DW-1:0] tree_val;

  kwm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LISTS)
  ) u_ctrl_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl_wr_en),
    .wr_addr_i (cur_list_q),
    .wr_data_i (ctrl_wr_data),
    .rd_en_i   (ctrl_rd_en),
    .rd_addr_i (ctrl_rd_addr),
    .rd_data_o (ctrl_raw)
  );

  kwm_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_LISTS << PW)
  ) u_list_ram (
    .clk_i     (clk_i),
    .wr_en_i   (dat_wr_en),
    .wr_addr_i (dat_wr_addr),
    .wr_data_i (req_q.value),
    .rd_en_i   (dat_rd_en),
    .rd_addr_i (dat_rd_addr),
    .rd_data_o (dat_rdata)
  );

  kwm_min_tree #(
    .NUM_LISTS (NUM_LISTS)
  ) u_min_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tree_start),
    .head_vld_i (head_vld_q),
    .head_val_i (head_val_q),
    .done_o     (tree_done),
    .idx_o      (tree_idx),
    .val_o      (tree_val)
  );

  // never-written pointer entries read as zero
  assign ctrl_entry   = ctrl_seen_q[ctrl_rd_addr_q] ? ctrl_raw : '0;
  assign ctrl_rp      = ctrl_entry[EW-1:CW];
  assign ctrl_cnt     = ctrl_entry[CW-1:0];
  assign ctrl_wr_data = {ctrl_wr_rp, ctrl_wr_cnt};
  assign next_rp      = wrap_pos(SW'(ctrl_rp) + SW'(1));

  assign in_list  = LW'(in_data_i.list_index);
  assign push_ok  = 32'(in_data_i.list_index) < 32'(NUM_LISTS);
  assign out_free = !out_vld_q || out_ready_i;

  // sequencer: next state and strobes
  always_comb begin
    state_d      = state_q;
    in_ready     = 1'b0;
    req_load     = 1'b0;
    out_load     = 1'b0;
    res_en       = 1'b0;
    res_d        = res_q;
    cur_load     = 1'b0;
    cur_list_d   = in_list;
    ctrl_rd_en   = 1'b0;
    ctrl_rd_addr = in_list;
    ctrl_wr_en   = 1'b0;
    ctrl_wr_rp   = ctrl_rp;
    ctrl_wr_cnt  = ctrl_cnt;
    dat_wr_en    = 1'b0;
    dat_wr_addr  = {cur_list_q, wrap_pos(SW'(ctrl_rp) + SW'(ctrl_cnt))};
    dat_rd_en    = 1'b0;
    dat_rd_addr  = {cur_list_q, next_rp};
    tree_start   = 1'b0;
    head_wr_en   = 1'b0;
    head_wr_vld  = 1'b1;
    head_wr_val  = dat_rdata;
    case (state_q)
      kwm_pkg::ST_IDLE, kwm_pkg::ST_RESP: begin
        if (state_q == kwm_pkg::ST_RESP) begin
          in_ready = out_free;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = kwm_pkg::ST_IDLE;
          end
        end else begin
          in_ready = 1'b1;
        end
        if (in_valid_i && in_ready) begin
          req_load = 1'b1;
          cur_load = 1'b1;
          res_d.out_value   = '0;
          res_d.source_list = '0;
          if (in_data_i.req_type == kwm_pkg::REQ_PUSH) begin
            if (push_ok) begin
              ctrl_rd_en = 1'b1;
              state_d    = kwm_pkg::ST_PUSH;
            end else begin
              res_en       = 1'b1;
              res_d.status = kwm_pkg::STAT_DROPPED;
              state_d      = kwm_pkg::ST_RESP;
            end
          end else if (|head_vld_q) begin
            tree_start = 1'b1;
            state_d    = kwm_pkg::ST_SCAN;
          end else begin
            res_en       = 1'b1;
            res_d.status = kwm_pkg::STAT_EMPTY;
            state_d      = kwm_pkg::ST_RESP;
          end
        end
      end
      kwm_pkg::ST_PUSH: begin
        res_en            = 1'b1;
        res_d.out_value   = '0;
        res_d.source_list = '0;
        state_d           = kwm_pkg::ST_RESP;
        if (ctrl_cnt == CW'(LIST_DEPTH)) begin
          res_d.status = kwm_pkg::STAT_DROPPED;
        end else begin
          res_d.status = kwm_pkg::STAT_PUSHED;
          dat_wr_en    = 1'b1;
          ctrl_wr_en   = 1'b1;
          ctrl_wr_cnt  = ctrl_cnt + CW'(1);
          if (ctrl_cnt == '0) begin
            head_wr_en  = 1'b1;
            head_wr_val = req_q.value;
          end
        end
      end
      kwm_pkg::ST_SCAN: begin
        if (tree_done) begin
          ctrl_rd_en        = 1'b1;
          ctrl_rd_addr      = tree_idx;
          cur_load          = 1'b1;
          cur_list_d        = tree_idx;
          res_en            = 1'b1;
          res_d.status      = kwm_pkg::STAT_POPPED;
          res_d.out_value   = tree_val;
          res_d.source_list = kwm_pkg::LIST_W'(tree_idx);
          state_d           = kwm_pkg::ST_POP_CTRL;
        end
      end
      kwm_pkg::ST_POP_CTRL: begin
        ctrl_wr_en  = 1'b1;
        ctrl_wr_rp  = next_rp;
        ctrl_wr_cnt = ctrl_cnt - CW'(1);
        if (ctrl_cnt != CW'(1)) begin
          dat_rd_en = 1'b1;
          state_d   = kwm_pkg::ST_POP_HEAD;
        end else begin
          head_wr_en  = 1'b1;
          head_wr_vld = 1'b0;
          state_d     = kwm_pkg::ST_RESP;
        end
      end
      kwm_pkg::ST_POP_HEAD: begin
        head_wr_en = 1'b1;
        state_d    = kwm_pkg::ST_RESP;
      end
      default: begin
        state_d = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      head_vld_q  <= '0;
      ctrl_seen_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (head_wr_en) begin
        head_vld_q[cur_list_q] <= head_wr_vld;
      end
      if (ctrl_wr_en) begin
        ctrl_seen_q[cur_list_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= in_data_i;
    end
    if (cur_load) begin
      cur_list_q <= cur_list_d;
    end
    if (ctrl_rd_en) begin
      ctrl_rd_addr_q <= ctrl_rd_addr;
    end
    if (res_en) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    if (head_wr_en && head_wr_vld) begin
      head_val_q[cur_list_q] <= head_wr_val;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // the min tree only ever picks a list with a live head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kwm_pkg::ST_SCAN && tree_done) |-> head_vld_q[tree_idx])
    else $error("min tree picked an empty list");

  // head valid bit follows the written fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_wr_en |=> (head_vld_q[$past(cur_list_q)] == ($past(ctrl_wr_cnt) != '0)))
    else $error("head valid out of step with fill count");

  // a result only appears out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == kwm_pkg::ST_RESP))
    else $error("result shown outside the response state");

endmodule
